// ===== rtl/core/bqd_pkg.sv =====
// ----------------------------------------------------------------------------
// Biquad section package
// Shared widths, register indexes, mode field positions, sequencer commands
// and the configuration record of the direct-form-II biquad section.
// ----------------------------------------------------------------------------
`default_nettype none

package bqd_pkg;

  localparam int IO_W       = 16;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 16;
  localparam int FRAC_W     = 5;
  localparam int MODE_W     = 7;
  localparam int SHIFT_W    = 6;

  localparam logic [FRAC_W-1:0] FRAC_RESET = 5'd14;

  // Positions inside the mode register.
  localparam int MODE_UPD_SAT = 0;
  localparam int MODE_ST_RND  = 1;
  localparam int MODE_ST_SAT  = 3;
  localparam int MODE_OUT_RND = 4;
  localparam int MODE_OUT_SAT = 6;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SCALE = 4'd0,
    REG_B0    = 4'd1,
    REG_B1    = 4'd2,
    REG_B2    = 4'd3,
    REG_A1    = 4'd4,
    REG_A2    = 4'd5,
    REG_FRAC  = 4'd6,
    REG_MODE  = 4'd7
  } bqd_reg_e;

  typedef enum logic [1:0] {
    RND_FLOOR     = 2'd0,
    RND_NEAR_UP   = 2'd1,
    RND_NEAR_EVEN = 2'd2,
    RND_TO_ZERO   = 2'd3
  } bqd_round_e;

  typedef enum logic [2:0] {
    MUL_X_SCALE = 3'd0,
    MUL_D1_A1   = 3'd1,
    MUL_D2_A2   = 3'd2,
    MUL_N_B0    = 3'd3,
    MUL_D1_B1   = 3'd4,
    MUL_D2_B2   = 3'd5
  } bqd_mul_sel_e;

  typedef struct packed {
    logic signed [IO_W-1:0] scale;
    logic signed [IO_W-1:0] b0;
    logic signed [IO_W-1:0] b1;
    logic signed [IO_W-1:0] b2;
    logic signed [IO_W-1:0] a1;
    logic signed [IO_W-1:0] a2;
    logic [FRAC_W-1:0]      frac;
    logic [MODE_W-1:0]      mode;
  } bqd_cfg_t;

  typedef struct packed {
    logic         in_load;
    bqd_mul_sel_e mul_sel;
    logic         acc_clr;
    logic         acc_en;
    logic         nd1_en;
    logic         out_en;
  } bqd_cmd_t;

endpackage

`default_nettype wire

// ===== rtl/core/bqd_in_if.sv =====
// ----------------------------------------------------------------------------
// Biquad input channel
// Valid/ready channel that carries one input sample per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface bqd_in_if;
  logic                            valid;
  logic                            ready;
  logic signed [bqd_pkg::IO_W-1:0] sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink   (input valid, input sample_in, output ready);
  modport mon    (input valid, input sample_in, input ready);
endinterface

`default_nettype wire

// ===== rtl/core/bqd_out_if.sv =====
// ----------------------------------------------------------------------------
// Biquad output channel
// Valid/ready channel that carries one filtered sample per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface bqd_out_if;
  logic                            valid;
  logic                            ready;
  logic signed [bqd_pkg::IO_W-1:0] sample_out;

  modport source (output valid, output sample_out, input ready);
  modport sink   (input valid, input sample_out, output ready);
  modport mon    (input valid, input sample_out, input ready);
endinterface

`default_nettype wire

// ===== rtl/core/bqd_cfg_if.sv =====
// ----------------------------------------------------------------------------
// Biquad configuration channel
// Valid/ready write channel carrying a register index and write data.
// ----------------------------------------------------------------------------
`default_nettype none

interface bqd_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [bqd_pkg::CFG_IDX_W-1:0]     index;
  logic [bqd_pkg::CFG_DATA_W-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
  modport mon    (input valid, input index, input data, input ready);
endinterface

`default_nettype wire

// ===== rtl/core/bqd_regs.sv =====
// ----------------------------------------------------------------------------
// Biquad configuration registers
// Holds the coefficients, fraction shift and mode bits; writes to indexes
// beyond the register list are dropped.
// ----------------------------------------------------------------------------
`default_nettype none

module bqd_regs (
  input  logic              clk_i,
  input  logic              rst_ni,
  bqd_cfg_if.sink           cfg_i,
  output bqd_pkg::bqd_cfg_t cfg_o
);
  import bqd_pkg::*;

  bqd_cfg_t cfg_q;

  assign cfg_i.ready = 1'b1;
  assign cfg_o       = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{scale: '0, b0: '0, b1: '0, b2: '0, a1: '0, a2: '0,
                 frac: FRAC_RESET, mode: '0};
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        REG_SCALE: cfg_q.scale <= cfg_i.data[IO_W-1:0];
        REG_B0:    cfg_q.b0    <= cfg_i.data[IO_W-1:0];
        REG_B1:    cfg_q.b1    <= cfg_i.data[IO_W-1:0];
        REG_B2:    cfg_q.b2    <= cfg_i.data[IO_W-1:0];
        REG_A1:    cfg_q.a1    <= cfg_i.data[IO_W-1:0];
        REG_A2:    cfg_q.a2    <= cfg_i.data[IO_W-1:0];
        REG_FRAC:  cfg_q.frac  <= cfg_i.data[FRAC_W-1:0];
        REG_MODE:  cfg_q.mode  <= cfg_i.data[MODE_W-1:0];
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/bqd_ctrl.sv =====
// ----------------------------------------------------------------------------
// Biquad sequencer
// One-hot state machine that steps the shared multiply-accumulate datapath
// through the state sum, its narrowing, the output sum and its narrowing.
// ----------------------------------------------------------------------------
`default_nettype none

module bqd_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output bqd_pkg::bqd_cmd_t cmd_o
);
  import bqd_pkg::*;

  typedef enum logic [10:0] {
    ST_IDLE = 11'b00000000001,
    ST_M0   = 11'b00000000010,
    ST_M1   = 11'b00000000100,
    ST_M2   = 11'b00000001000,
    ST_M3   = 11'b00000010000,
    ST_NS   = 11'b00000100000,
    ST_M4   = 11'b00001000000,
    ST_M5   = 11'b00010000000,
    ST_M6   = 11'b00100000000,
    ST_M7   = 11'b01000000000,
    ST_NO   = 11'b10000000000
  } bqd_state_e;

  bqd_state_e state_q, state_d;
  logic       out_valid_q, out_valid_d;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d       = state_q;
    out_valid_d   = out_valid_q && !out_ready_i;
    cmd_o         = '0;
    cmd_o.mul_sel = MUL_X_SCALE;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.in_load = 1'b1;
          state_d       = ST_M0;
        end
      end
      ST_M0: begin
        cmd_o.mul_sel = MUL_X_SCALE;
        state_d       = ST_M1;
      end
      ST_M1: begin
        cmd_o.mul_sel = MUL_D1_A1;
        cmd_o.acc_clr = 1'b1;
        cmd_o.acc_en  = 1'b1;
        state_d       = ST_M2;
      end
      ST_M2: begin
        cmd_o.mul_sel = MUL_D2_A2;
        cmd_o.acc_en  = 1'b1;
        state_d       = ST_M3;
      end
      ST_M3: begin
        cmd_o.acc_en = 1'b1;
        state_d      = ST_NS;
      end
      ST_NS: begin
        cmd_o.nd1_en = 1'b1;
        state_d      = ST_M4;
      end
      ST_M4: begin
        cmd_o.mul_sel = MUL_N_B0;
        state_d       = ST_M5;
      end
      ST_M5: begin
        cmd_o.mul_sel = MUL_D1_B1;
        cmd_o.acc_clr = 1'b1;
        cmd_o.acc_en  = 1'b1;
        state_d       = ST_M6;
      end
      ST_M6: begin
        cmd_o.mul_sel = MUL_D2_B2;
        cmd_o.acc_en  = 1'b1;
        state_d       = ST_M7;
      end
      ST_M7: begin
        cmd_o.acc_en = 1'b1;
        state_d      = ST_NO;
      end
      ST_NO: begin
        // The result register must be empty, or emptied in this cycle.
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_en = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/bqd_dp.sv =====
// ----------------------------------------------------------------------------
// Biquad datapath
// Shared multiplier with product register, wrapping or saturating
// accumulator, rounding narrower and the two delay words.
// ----------------------------------------------------------------------------
`default_nettype none

module bqd_dp #(
  parameter int SAMPLE_WIDTH = 16,
  parameter int ACC_WIDTH    = 40
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  bqd_pkg::bqd_cfg_t                    cfg_i,
  input  bqd_pkg::bqd_cmd_t                    cmd_i,
  input  logic signed [bqd_pkg::IO_W-1:0]      sample_in_i,
  output logic signed [bqd_pkg::IO_W-1:0]      sample_out_o
);
  import bqd_pkg::*;

  localparam int SW   = SAMPLE_WIDTH;
  localparam int AW   = ACC_WIDTH;
  localparam int PW   = 2 * SW;
  localparam int SUMW = ((AW > PW) ? AW : PW) + 1;
  localparam int NW   = (AW > SW) ? AW : SW;
  localparam int RW   = NW + 1;
  localparam int XW   = (SW > IO_W) ? SW : IO_W;

  localparam logic signed [SUMW-1:0] ACC_MAX_S = {{(SUMW-AW+1){1'b0}}, {(AW-1){1'b1}}};
  localparam logic signed [SUMW-1:0] ACC_MIN_S = {{(SUMW-AW+1){1'b1}}, {(AW-1){1'b0}}};
  localparam logic signed [RW-1:0]   SMP_MAX_R = {{(RW-SW+1){1'b0}}, {(SW-1){1'b1}}};
  localparam logic signed [RW-1:0]   SMP_MIN_R = {{(RW-SW+1){1'b1}}, {(SW-1){1'b0}}};
  localparam logic [SHIFT_W-1:0]     SW_SHIFT  = SHIFT_W'(SW);

  // A 16-bit field is sign-extended, then wrapped to the sample width.
  function automatic logic signed [SW-1:0] opnd(input logic signed [IO_W-1:0] raw);
    logic signed [31:0] e;
    e = 32'(raw);
    return e[SW-1:0];
  endfunction

  function automatic logic signed [SW-1:0] narrow(
    input logic signed [AW-1:0] a,
    input logic [SHIFT_W-1:0]   f,
    input bqd_round_e           rm,
    input logic                 sat
  );
    logic signed [NW-1:0] ext;
    logic signed [NW-1:0] sh;
    logic [NW-1:0]        mask;
    logic [NW-1:0]        rem;
    logic [NW-1:0]        half;
    logic                 inc;
    logic signed [RW-1:0] r;
    ext  = NW'(a);
    sh   = ext >>> f;
    mask = ~({NW{1'b1}} << f);
    rem  = ext & mask;
    half = mask ^ (mask >> 1);
    inc  = 1'b0;
    if (f != '0) begin
      case (rm)
        RND_NEAR_UP:   inc = (rem >= half);
        RND_NEAR_EVEN: inc = (rem > half) || ((rem == half) && sh[0]);
        RND_TO_ZERO:   inc = ext[NW-1] && (rem != '0);
        default:       inc = 1'b0;
      endcase
    end
    r = RW'(sh) + {{(RW-1){1'b0}}, inc};
    if (sat && (r > SMP_MAX_R)) begin
      r = SMP_MAX_R;
    end else if (sat && (r < SMP_MIN_R)) begin
      r = SMP_MIN_R;
    end
    return r[SW-1:0];
  endfunction

  logic signed [SW-1:0]   x_q, d1_q, d2_q, nd1_q;
  logic signed [PW-1:0]   prod_q, prod_d;
  logic signed [AW-1:0]   acc_q, acc_d, acc_base;
  logic signed [SUMW-1:0] sum;
  logic signed [SW-1:0]   mul_l, mul_r;
  logic signed [SW-1:0]   nd1_d, y;
  logic signed [XW-1:0]   y_ext;
  logic signed [IO_W-1:0] out_q;
  logic [SHIFT_W-1:0]     frac_eff;
  logic                   upd_sat;

  assign frac_eff = ({1'b0, cfg_i.frac} > SW_SHIFT) ? SW_SHIFT : {1'b0, cfg_i.frac};
  assign upd_sat  = cfg_i.mode[MODE_UPD_SAT];

  always_comb begin
    case (cmd_i.mul_sel)
      MUL_X_SCALE: begin mul_l = x_q;   mul_r = opnd(cfg_i.scale); end
      MUL_D1_A1:   begin mul_l = d1_q;  mul_r = opnd(cfg_i.a1);    end
      MUL_D2_A2:   begin mul_l = d2_q;  mul_r = opnd(cfg_i.a2);    end
      MUL_N_B0:    begin mul_l = nd1_q; mul_r = opnd(cfg_i.b0);    end
      MUL_D1_B1:   begin mul_l = d1_q;  mul_r = opnd(cfg_i.b1);    end
      MUL_D2_B2:   begin mul_l = d2_q;  mul_r = opnd(cfg_i.b2);    end
      default:     begin mul_l = x_q;   mul_r = opnd(cfg_i.scale); end
    endcase
  end

  assign prod_d = mul_l * mul_r;

  // The sum is exact at one bit beyond the wider of accumulator and product.
  always_comb begin
    acc_base = cmd_i.acc_clr ? '0 : acc_q;
    sum      = SUMW'(acc_base) + SUMW'(prod_q);
    if (upd_sat && (sum > ACC_MAX_S)) begin
      acc_d = ACC_MAX_S[AW-1:0];
    end else if (upd_sat && (sum < ACC_MIN_S)) begin
      acc_d = ACC_MIN_S[AW-1:0];
    end else begin
      acc_d = sum[AW-1:0];
    end
  end

  assign nd1_d = narrow(acc_q, frac_eff, bqd_round_e'(cfg_i.mode[MODE_ST_RND +: 2]),
                        cfg_i.mode[MODE_ST_SAT]);
  assign y     = narrow(acc_q, frac_eff, bqd_round_e'(cfg_i.mode[MODE_OUT_RND +: 2]),
                        cfg_i.mode[MODE_OUT_SAT]);
  assign y_ext = XW'(y);

  assign sample_out_o = out_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.in_load) begin
      x_q <= opnd(sample_in_i);
    end
    prod_q <= prod_d;
    if (cmd_i.acc_en) begin
      acc_q <= acc_d;
    end
    if (cmd_i.nd1_en) begin
      nd1_q <= nd1_d;
    end
    if (cmd_i.out_en) begin
      out_q <= y_ext[IO_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d1_q <= '0;
      d2_q <= '0;
    end else if (cmd_i.out_en) begin
      d2_q <= d1_q;
      d1_q <= nd1_q;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/fixed_point_biquad_df2_section.sv =====
// An accepted sample steps through the states M0 to M3, NS, M4 to M7 and NO,
// and its result is written to the output register as NO is left. A new sample
// is taken only in idle; the single multiplier forms the six products in turn
// and NS and NO round the sums. A finished result waits in the output register
// while the next sample is taken. Reset clears the delay words, sets the
// coefficients to zero, the fraction shift to 14 and the mode bits to zero.
// ----------------------------------------------------------------------------
// Fixed-point direct-form-II biquad section
// Top level: configuration registers, sequencer and shared MAC datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module fixed_point_biquad_df2_section #(
  parameter int SAMPLE_WIDTH = 16,
  parameter int ACC_WIDTH    = 40
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  bqd_cfg_if.sink cfg_i,
  bqd_in_if.sink  in_i,
  bqd_out_if.source out_o
);
  import bqd_pkg::*;

  bqd_cfg_t cfg;
  bqd_cmd_t cmd;

  bqd_regs u_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  bqd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .cmd_o       (cmd)
  );

  bqd_dp #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .ACC_WIDTH    (ACC_WIDTH)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .cmd_i        (cmd),
    .sample_in_i  (in_i.sample_in),
    .sample_out_o (out_o.sample_out)
  );

endmodule

`default_nettype wire

// ===== rtl/core/bqd_checker.sv =====
// ----------------------------------------------------------------------------
// Biquad port checker
// Watches the channel ports of the biquad section over time.
// ----------------------------------------------------------------------------
`default_nettype none

module bqd_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_valid_i,
  input logic                           in_ready_i,
  input logic                           out_valid_i,
  input logic                           out_ready_i,
  input logic [bqd_pkg::IO_W-1:0]       sample_out_i
);

  // Only one sample is in flight, so the input closes right after a transaction.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i) |=> !in_ready_i)
    else $error("input ready after an accepted sample");

  // A result appears only while a sample is being processed.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(!in_ready_i))
    else $error("result without a sample in flight");

  assert property (@(posedge clk_i)
    !rst_ni |-> !out_valid_i)
    else $error("result valid during reset");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> (out_valid_i && $stable(sample_out_i)))
    else $error("stalled result dropped or changed");

endmodule

bind fixed_point_biquad_df2_section bqd_checker u_bqd_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .sample_out_i (out_o.sample_out)
);

`default_nettype wire

// ===== test/fixed_point_biquad_df2_section_tb.sv =====
// ----------------------------------------------------------------------------
// Biquad section testbench
// Drives samples and register writes into the direct-form-II biquad section.
// A tracker class predicts each filtered sample and checks it against the
// results as they leave the block. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

import bqd_pkg::*;

class biquad_tracker;
  localparam int     ACC_W      = 40;
  localparam longint ACC_MAX    = (longint'(1) <<< (ACC_W - 1)) - 1;
  localparam longint ACC_MIN    = -(longint'(1) <<< (ACC_W - 1));
  localparam longint SAMPLE_MAX = 32767;
  localparam longint SAMPLE_MIN = -32768;
  localparam int     FRAC_LIMIT = IO_W;

  logic signed [IO_W-1:0] gain_x, ff0, ff1, ff2, fb1, fb2;
  logic [FRAC_W-1:0]      frac_shift;
  logic [MODE_W-1:0]      mode_word;
  logic signed [IO_W-1:0] state_w1, state_w2;
  logic signed [IO_W-1:0] expected_out_q[$];
  int unsigned            mismatches;

  function new();
    gain_x = '0;
    ff0 = '0;
    ff1 = '0;
    ff2 = '0;
    fb1 = '0;
    fb2 = '0;
    frac_shift = FRAC_RESET;
    mode_word = '0;
    state_w1 = '0;
    state_w2 = '0;
    mismatches = 0;
  endfunction

  function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_SCALE: gain_x = data;
      REG_B0:    ff0 = data;
      REG_B1:    ff1 = data;
      REG_B2:    ff2 = data;
      REG_A1:    fb1 = data;
      REG_A2:    fb2 = data;
      REG_FRAC:  frac_shift = data[FRAC_W-1:0];
      REG_MODE:  mode_word = data[MODE_W-1:0];
      default: ;
    endcase
  endfunction

  // One multiply-add, wrapped or clamped to the accumulator width.
  function longint accumulate(longint acc, logic signed [IO_W-1:0] lhs,
                              logic signed [IO_W-1:0] rhs, bit sat);
    longint                  sum;
    logic signed [ACC_W-1:0] wrapped;
    sum = acc + longint'(lhs) * longint'(rhs);
    if (sat) begin
      if (sum > ACC_MAX) return ACC_MAX;
      if (sum < ACC_MIN) return ACC_MIN;
      return sum;
    end
    wrapped = sum[ACC_W-1:0];
    return wrapped;
  endfunction

  function logic signed [IO_W-1:0] round_narrow(longint acc, int unsigned f,
                                                bqd_round_e rm, bit sat);
    longint r, rem, half;
    bit     neg;
    r = acc;
    if (f != 0) begin
      rem  = acc & ((longint'(1) <<< f) - 1);
      half = longint'(1) <<< (f - 1);
      neg  = acc < 0;
      r    = acc >>> f;
      case (rm)
        RND_NEAR_UP:   if (rem >= half) r++;
        RND_NEAR_EVEN: if (rem > half || (rem == half && r[0])) r++;
        RND_TO_ZERO:   if (neg && rem != 0) r++;
        default: ;
      endcase
    end
    if (sat) begin
      if (r < SAMPLE_MIN) r = SAMPLE_MIN;
      else if (r > SAMPLE_MAX) r = SAMPLE_MAX;
    end
    return r[IO_W-1:0];
  endfunction

  function void take_sample(logic signed [IO_W-1:0] x);
    int unsigned            f;
    bit                     upd_sat;
    longint                 acc;
    logic signed [IO_W-1:0] new_w1, y;
    f = (frac_shift > FRAC_LIMIT) ? FRAC_LIMIT : frac_shift;
    upd_sat = mode_word[MODE_UPD_SAT];
    acc = accumulate(0, x, gain_x, upd_sat);
    acc = accumulate(acc, state_w1, fb1, upd_sat);
    acc = accumulate(acc, state_w2, fb2, upd_sat);
    new_w1 = round_narrow(acc, f, bqd_round_e'(mode_word[MODE_ST_RND +: 2]),
                          mode_word[MODE_ST_SAT]);
    acc = accumulate(0, new_w1, ff0, upd_sat);
    acc = accumulate(acc, state_w1, ff1, upd_sat);
    acc = accumulate(acc, state_w2, ff2, upd_sat);
    y = round_narrow(acc, f, bqd_round_e'(mode_word[MODE_OUT_RND +: 2]),
                     mode_word[MODE_OUT_SAT]);
    state_w2 = state_w1;
    state_w1 = new_w1;
    expected_out_q.push_back(y);
  endfunction

  function void check_sample_out(logic signed [IO_W-1:0] y);
    logic signed [IO_W-1:0] want;
    if (expected_out_q.size() == 0) begin
      $error("sample_out: expected none outstanding, actual %0d", y);
      mismatches++;
      return;
    end
    want = expected_out_q.pop_front();
    if (y !== want) begin
      $error("sample_out: expected %0d, actual %0d", want, y);
      mismatches++;
    end
  endfunction

  function int outstanding();
    return expected_out_q.size();
  endfunction

  function void flag_leftover();
    if (expected_out_q.size() != 0) begin
      $error("sample_out: expected %0d more results, actual none",
             expected_out_q.size());
      mismatches++;
    end
  endfunction
endclass

module fixed_point_biquad_df2_section_tb;

  localparam int RANDOM_SAMPLES = 550;

  logic clk_i;
  logic rst_ni;
  bit   in_gap_on;
  bit   out_stall_on;

  bqd_cfg_if cfg_bus ();
  bqd_in_if  sample_bus ();
  bqd_out_if result_bus ();

  biquad_tracker tracker = new();

  fixed_point_biquad_df2_section u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_bus),
    .in_i   (sample_bus),
    .out_o  (result_bus)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned pick_gap();
    if ($urandom_range(0, 9) < 9) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [IO_W-1:0] pick_word();
    case ($urandom_range(0, 7))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return 16'($signed($urandom_range(0, 511)) - 256);
      3:       return 16'($signed($urandom_range(0, 32767)) - 16384);
      default: return 16'($urandom);
    endcase
  endfunction

  // Leaves valid high so that back-to-back writes follow without a gap.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= data;
    @(posedge clk_i);
    while (!cfg_bus.ready) @(posedge clk_i);
    tracker.write_reg(idx, data);
  endtask

  task automatic send_sample(logic signed [IO_W-1:0] x);
    int unsigned gap;
    gap = (in_gap_on && $urandom_range(0, 2) == 0) ? pick_gap() : 0;
    if (gap != 0) begin
      sample_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    sample_bus.valid     <= 1'b1;
    sample_bus.sample_in <= x;
    @(posedge clk_i);
    while (!sample_bus.ready) @(posedge clk_i);
    tracker.take_sample(x);
  endtask

  // Waits for every expected result, then lets the pipeline settle.
  task automatic settle();
    int unsigned n;
    n = 0;
    sample_bus.valid <= 1'b0;
    while (tracker.outstanding() != 0 && n < 5000) begin
      @(posedge clk_i);
      n++;
    end
    repeat (20) @(posedge clk_i);
  endtask

  task automatic random_setup(bit all_regs);
    bqd_reg_e               r;
    logic [CFG_DATA_W-1:0]  d;
    r = r.first();
    do begin
      if (all_regs || $urandom_range(0, 1) == 1) begin
        case (r)
          REG_FRAC: d = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                        : {11'($urandom), 5'($urandom_range(8, 16))};
          REG_MODE: d = 16'($urandom);
          default:  d = pick_word();
        endcase
        write_reg(r, d);
      end
      r = r.next();
    end while (r != r.first());
    // Indexes past the last register must be ignored.
    if ($urandom_range(0, 3) == 0)
      write_reg(CFG_IDX_W'(int'(REG_MODE) + $urandom_range(1, 8)), 16'($urandom));
    cfg_bus.valid <= 1'b0;
  endtask

  initial begin
    int unsigned stall_left;
    stall_left = 0;
    result_bus.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && result_bus.valid && result_bus.ready)
        tracker.check_sample_out(result_bus.sample_out);
      if (stall_left != 0) begin
        result_bus.ready <= 1'b0;
        stall_left--;
      end else if (out_stall_on && $urandom_range(0, 3) == 0) begin
        result_bus.ready <= 1'b0;
        stall_left = pick_gap() - 1;
      end else begin
        result_bus.ready <= 1'b1;
      end
    end
  end

  initial begin
    bqd_round_e  rm;
    int unsigned sent;
    int unsigned batch;
    rst_ni               <= 1'b0;
    cfg_bus.valid        <= 1'b0;
    cfg_bus.index        <= '0;
    cfg_bus.data         <= '0;
    sample_bus.valid     <= 1'b0;
    sample_bus.sample_in <= '0;
    in_gap_on    = 1'b1;
    out_stall_on = 1'b1;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Coefficients are all zero out of reset, so every output is zero.
    send_sample(16'sh7FFF);
    send_sample(-16'sh8000);
    send_sample(16'sh0000);
    send_sample(-16'sh0001);
    settle();

    // Full-scale coefficients with no fraction bits: the state word wraps.
    write_reg(REG_SCALE, 16'h7FFF);
    write_reg(REG_B0, 16'h7FFF);
    write_reg(REG_B1, 16'h8000);
    write_reg(REG_B2, 16'h7FFF);
    write_reg(REG_A1, 16'h8000);
    write_reg(REG_A2, 16'h7FFF);
    write_reg(REG_FRAC, 16'h0000);
    write_reg(REG_MODE, 16'h0000);
    cfg_bus.valid <= 1'b0;
    send_sample(16'sh7FFF);
    send_sample(-16'sh8000);
    send_sample(16'sh7FFF);
    send_sample(-16'sh8000);
    settle();

    // Oversized shift is clamped; every saturate bit set.
    write_reg(REG_FRAC, 16'hFFFF);
    write_reg(REG_MODE, 16'hFFFF);
    cfg_bus.valid <= 1'b0;
    send_sample(-16'sh8000);
    send_sample(16'sh7FFF);
    send_sample(16'sh0001);
    send_sample(-16'sh0001);
    settle();

    // A one-bit shift of odd values lands on ties in the state stage.
    write_reg(REG_SCALE, 16'h0001);
    write_reg(REG_B0, 16'h0001);
    write_reg(REG_B1, 16'h0000);
    write_reg(REG_B2, 16'h0000);
    write_reg(REG_A1, 16'h0000);
    write_reg(REG_A2, 16'h0000);
    write_reg(REG_FRAC, 16'h0001);
    rm = rm.first();
    do begin
      write_reg(REG_MODE, CFG_DATA_W'(rm) << MODE_ST_RND
                          | CFG_DATA_W'(bqd_round_e'(rm.next())) << MODE_OUT_RND);
      cfg_bus.valid <= 1'b0;
      send_sample(-16'sh0003);
      send_sample(16'sh0001);
      send_sample(16'sh0003);
      settle();
      rm = rm.next();
    end while (rm != rm.first());

    sent = 0;
    while (sent < RANDOM_SAMPLES) begin
      random_setup(sent == 0);
      in_gap_on    = $urandom_range(0, 4) != 0;
      out_stall_on = $urandom_range(0, 4) != 0;
      batch = $urandom_range(10, 60);
      repeat (batch) send_sample(pick_word());
      sent += batch;
      settle();
    end

    tracker.flag_leftover();
    if (tracker.mismatches == 0) begin
      $display("fixed_point_biquad_df2_section_tb: done, clean");
    end else begin
      $display("fixed_point_biquad_df2_section_tb: done, errors");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("fixed_point_biquad_df2_section_tb: done, errors");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/bqd_pkg.sv
rtl/core/bqd_in_if.sv
rtl/core/bqd_out_if.sv
rtl/core/bqd_cfg_if.sv
rtl/core/bqd_regs.sv
rtl/core/bqd_ctrl.sv
rtl/core/bqd_dp.sv
rtl/core/fixed_point_biquad_df2_section.sv
rtl/core/bqd_checker.sv
test/fixed_point_biquad_df2_section_tb.sv
